### design/mphr_pkg.sv
// Package for the maximum-height raster: sizes, register indexes and types.
`default_nettype none
package mphr_pkg;
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS = 64;
    localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int COL_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam logic signed [31:0] LOWEST_HEIGHT = 32'sh8000_0000;
    localparam logic [16:0] DIAG_SCALE = 17'd46341;

    localparam logic [2:0] REG_X_ORIGIN = 3'd0;
    localparam logic [2:0] REG_Y_TOP = 3'd1;
    localparam logic [2:0] REG_CELL_SIZE = 3'd2;
    localparam logic [2:0] REG_COLUMNS_USED = 3'd3;
    localparam logic [2:0] REG_ROWS_USED = 3'd4;
    localparam logic [2:0] REG_FOOTPRINT_RADIUS = 3'd5;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic start;
        logic signed [33:0] dividend;
        logic [19:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic signed [34:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

### design/mphr_divider.sv
// Restoring floor divider, one quotient bit per cycle.
`default_nettype none
module mphr_divider
    import mphr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    logic [33:0] r_quo, n_quo;
    logic [20:0] r_rem, n_rem;
    logic [19:0] r_dsr, n_dsr;
    logic        r_neg, n_neg;
    logic        r_done, n_done;
    logic [20:0] w_trial;
    logic [34:0] w_q;

    always_comb begin
        n_busy = r_busy;
        n_cnt = r_cnt;
        n_quo = r_quo;
        n_rem = r_rem;
        n_dsr = r_dsr;
        n_neg = r_neg;
        n_done = 1'b0;
        w_trial = {r_rem[19:0], r_quo[33]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt = 6'd34;
            n_neg = i_req.dividend[33];
            n_quo = i_req.dividend[33] ? 34'(-i_req.dividend) : 34'(i_req.dividend);
            n_rem = '0;
            n_dsr = i_req.divisor;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dsr}) begin
                n_rem = w_trial - {1'b0, r_dsr};
                n_quo = {r_quo[32:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[32:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Negative dividends round toward minus infinity.
    always_comb begin
        if (r_neg) begin
            w_q = (r_rem != '0) ? -{1'b0, r_quo} - 35'd1 : -{1'b0, r_quo};
        end else begin
            w_q = {1'b0, r_quo};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quotient = w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_neg <= n_neg;
    end
endmodule
`default_nettype wire

### design/max_point_height_raster.sv
// Top level of the maximum-height raster: registers, sequencer and height memory.
//
// Usage: pulse i_start with o_busy low to issue one transaction. i_operation
// selects add-point (0) or read-cell (1). Every transaction gives exactly one
// result, shown for one cycle with o_valid high; the receiver cannot stall it.
// A read keeps o_busy high through S_RDC (memory read) and S_RDO (registered
// output); its result is strobed once S_RDO is left, when o_busy is already low.
// An add-point runs up to nine footprint spots in turn; each spot needs two passes
// through the one shared 34-bit serial divider (column then row); with radius 0
// only the centre spot runs. The result of an add is strobed in the first cycle
// with o_busy low after its last spot.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at once
// and are to be made only while o_busy is low; the block does not enforce this.
// After reset a clearing pass writes the lowest height to all 4096 cells, one
// per cycle; o_busy stays high throughout the clearing pass.
`default_nettype none
module max_point_height_raster
    import mphr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic               i_operation,
    input  wire logic signed [31:0] i_point_x,
    input  wire logic signed [31:0] i_point_y,
    input  wire logic signed [31:0] i_point_z,
    input  wire logic [11:0]        i_cell_index,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    output logic                    o_valid,
    output logic signed [31:0]      o_cell_height,
    output logic                    o_cell_has_value,
    output logic [3:0]              o_dropped_spots
);
    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_SPOT  = 9'b000000100,
        S_COL   = 9'b000001000,
        S_ROW   = 9'b000010000,
        S_RD    = 9'b000100000,
        S_WR    = 9'b001000000,
        S_RDC   = 9'b010000000,
        S_RDO   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic signed [31:0] r_x_origin, r_y_top;
    logic [19:0]        r_cell_size, r_radius;
    logic [6:0]         r_cols_used, r_rows_used;

    logic signed [31:0] r_px, r_py, r_pz;
    logic [3:0]         r_spot;
    logic [3:0]         r_drop;
    logic [19:0]        r_diag;
    logic signed [34:0] r_col;
    logic signed [33:0] r_sy, r_sz;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W:0]    r_clr;
    logic [11:0]        r_rd_idx;

    logic signed [31:0] mem [STORE_DEPTH];
    logic signed [31:0] r_mem_q;

    t_div_req w_req;
    t_div_rsp w_rsp;
    logic [36:0] w_diag_prod;
    logic signed [21:0] w_dx, w_dy;
    logic [1:0] w_dz;
    logic [COL_W-1:0] w_cols;
    logic [ROW_W-1:0] w_rows;
    logic w_off;
    logic signed [31:0] w_h;

    mphr_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_diag_prod = {17'd0, r_radius} * {20'd0, DIAG_SCALE};
    assign w_cols = (r_cols_used > 7'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS) : COL_W'(r_cols_used);
    assign w_rows = (r_rows_used > 7'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : ROW_W'(r_rows_used);

    // Footprint offsets: centre, four cardinal spots, four diagonal spots.
    always_comb begin
        w_dx = '0;
        w_dy = '0;
        w_dz = 2'd0;
        case (r_spot)
            4'd0: begin end
            4'd1: begin w_dx = 22'(r_radius); w_dz = 2'd1; end
            4'd2: begin w_dx = -22'(r_radius); w_dz = 2'd1; end
            4'd3: begin w_dy = 22'(r_radius); w_dz = 2'd1; end
            4'd4: begin w_dy = -22'(r_radius); w_dz = 2'd1; end
            4'd5: begin w_dx = 22'(r_diag); w_dy = 22'(r_diag); w_dz = 2'd2; end
            4'd6: begin w_dx = 22'(r_diag); w_dy = -22'(r_diag); w_dz = 2'd2; end
            4'd7: begin w_dx = -22'(r_diag); w_dy = 22'(r_diag); w_dz = 2'd2; end
            4'd8: begin w_dx = -22'(r_diag); w_dy = -22'(r_diag); w_dz = 2'd2; end
            default: begin end
        endcase
    end

    always_comb begin
        w_req.start = 1'b0;
        w_req.dividend = '0;
        w_req.divisor = (r_cell_size == '0) ? 20'd1 : r_cell_size;
        if (r_state == S_SPOT) begin
            w_req.start = 1'b1;
            w_req.dividend = 34'(r_px) + 34'(w_dx) - 34'(r_x_origin);
        end else if (r_state == S_COL && w_rsp.done) begin
            w_req.start = 1'b1;
            w_req.dividend = 34'(r_y_top) - r_sy;
        end
    end

    assign w_off = (r_col < 0) || (r_col >= 35'(w_cols)) || (w_rsp.quotient < 0)
                || (w_rsp.quotient >= 35'(w_rows));
    assign w_h = (r_sz <= 34'(LOWEST_HEIGHT)) ? LOWEST_HEIGHT + 32'sd1 : r_sz[31:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == (ADDR_W + 1)'(STORE_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_start) n_state = (i_operation == OP_READ) ? S_RDC : S_SPOT;
            end
            S_SPOT: n_state = S_COL;
            S_COL: if (w_rsp.done) n_state = S_ROW;
            S_ROW: begin
                if (w_rsp.done) begin
                    if (w_off) n_state = (r_radius == '0 || r_spot == 4'd8) ? S_IDLE : S_SPOT;
                    else n_state = S_RD;
                end
            end
            S_RD: n_state = S_WR;
            S_WR: n_state = (r_radius == '0 || r_spot == 4'd8) ? S_IDLE : S_SPOT;
            S_RDC: n_state = S_RDO;
            S_RDO: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_x_origin <= '0;
            r_y_top <= '0;
            r_cell_size <= 20'd1000;
            r_cols_used <= 7'd64;
            r_rows_used <= 7'd64;
            r_radius <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_X_ORIGIN: r_x_origin <= i_cfg_data;
                    REG_Y_TOP: r_y_top <= i_cfg_data;
                    REG_CELL_SIZE: r_cell_size <= i_cfg_data[19:0];
                    REG_COLUMNS_USED: r_cols_used <= i_cfg_data[6:0];
                    REG_ROWS_USED: r_rows_used <= i_cfg_data[6:0];
                    REG_FOOTPRINT_RADIUS: r_radius <= i_cfg_data[19:0];
                    default: begin end
                endcase
            end
            if (r_state == S_ROW && w_rsp.done && w_off
                    && (r_radius == '0 || r_spot == 4'd8)) o_valid <= 1'b1;
            if (r_state == S_WR && (r_radius == '0 || r_spot == 4'd8)) o_valid <= 1'b1;
            if (r_state == S_RDO) o_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
            r_pz <= i_point_z;
            r_rd_idx <= i_cell_index;
            r_spot <= 4'd0;
            r_drop <= '0;
            r_diag <= w_diag_prod[35:16];
        end
        // Row coordinate and height of the current spot settle while the column divide runs.
        r_sy <= 34'(r_py) + 34'(w_dy);
        r_sz <= 34'(r_pz) - 34'(w_dz);
        if (r_state == S_COL && w_rsp.done) r_col <= w_rsp.quotient;
        if (r_state == S_ROW && w_rsp.done) begin
            r_addr <= ADDR_W'(w_rsp.quotient[11:0] * w_cols + r_col[11:0]);
            if (w_off) begin
                r_drop <= r_drop + 4'd1;
                r_spot <= r_spot + 4'd1;
            end
        end
        if (r_state == S_WR) r_spot <= r_spot + 4'd1;
        if (r_state == S_ROW && w_rsp.done && w_off) begin
            o_cell_height <= '0;
            o_cell_has_value <= 1'b0;
            o_dropped_spots <= r_drop + 4'd1;
        end else if (r_state == S_WR) begin
            o_cell_height <= '0;
            o_cell_has_value <= 1'b0;
            o_dropped_spots <= r_drop;
        end else if (r_state == S_RDO) begin
            o_cell_height <= r_mem_q;
            o_cell_has_value <= (r_mem_q != LOWEST_HEIGHT);
            o_dropped_spots <= '0;
        end
    end

    // Height memory: one read and one write address; read-modify-write across S_RD and S_WR.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            mem[r_clr[ADDR_W-1:0]] <= LOWEST_HEIGHT;
        end else if (r_state == S_WR && w_h > r_mem_q) begin
            mem[r_addr] <= w_h;
        end
        if (r_state == S_RDC) r_mem_q <= mem[r_rd_idx[ADDR_W-1:0]];
        else r_mem_q <= mem[r_addr];
    end

    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire
